>>> hdl/pur_pkg.sv
// Package for the rotating permutation unranking core.
// Holds widths, the factorial tables, the queue entry type and small helpers.
// No dependencies.
package pur_pkg;

  localparam int MaxItems   = 12;
  localparam int CountW     = 4;
  localparam int SerialW    = 29;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = $clog2(QueueDepth);

  typedef logic [CountW-1:0] cnt_t;

  // One factorial digit handed from the front to the back.
  typedef struct packed {
    cnt_t digit;
    logic last;
    logic oor;
  } pur_entry_t;

  typedef logic [MaxItems-1:0][MaxItems-1:0][SerialW-1:0] mul_tab_t;

  function automatic logic [SerialW-1:0] fact_lut(input cnt_t k);
    logic [SerialW-1:0] f;
    unique case (k)
      4'd0:    f = SerialW'(1);
      4'd1:    f = SerialW'(1);
      4'd2:    f = SerialW'(2);
      4'd3:    f = SerialW'(6);
      4'd4:    f = SerialW'(24);
      4'd5:    f = SerialW'(120);
      4'd6:    f = SerialW'(720);
      4'd7:    f = SerialW'(5040);
      4'd8:    f = SerialW'(40320);
      4'd9:    f = SerialW'(362880);
      4'd10:   f = SerialW'(3628800);
      4'd11:   f = SerialW'(39916800);
      default: f = SerialW'(479001600);
    endcase
    return f;
  endfunction

  // MulTab[k][d] = d * k!, built at elaboration.
  function automatic mul_tab_t build_mul_tab();
    mul_tab_t t;
    t = '0;
    for (int k = 0; k < MaxItems; k++) begin
      for (int d = 0; d < MaxItems; d++) begin
        t[k][d] = SerialW'(int'(fact_lut(CountW'(k))) * d);
      end
    end
    return t;
  endfunction

  localparam mul_tab_t MulTab = build_mul_tab();

  function automatic cnt_t popcount(input logic [MaxItems-1:0] v);
    cnt_t c;
    c = '0;
    for (int i = 0; i < MaxItems; i++) begin
      c = c + cnt_t'(v[i]);
    end
    return c;
  endfunction

  function automatic cnt_t eff_count(input cnt_t raw);
    cnt_t n;
    n = raw;
    if (raw == '0) begin
      n = cnt_t'(1);
    end else if (raw > cnt_t'(MaxItems)) begin
      n = cnt_t'(MaxItems);
    end
    return n;
  endfunction

endpackage

>>> hdl/pur_if.sv
// Valid/ready channel interfaces for the rotating permutation unranking core.
// Depends on pur_pkg.
interface pur_in_if
  import pur_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [SerialW-1:0] serial_number;

  modport source (output valid, output serial_number, input ready);
  modport sink   (input valid, input serial_number, output ready);
endinterface

interface pur_out_if
  import pur_pkg::*;
();
  logic valid;
  logic ready;
  cnt_t slot;
  cnt_t element_index;
  logic last;
  logic out_of_range;

  modport source (output valid, output slot, output element_index, output last,
                  output out_of_range, input ready);
  modport sink   (input valid, input slot, input element_index, input last,
                  input out_of_range, output ready);
endinterface

>>> hdl/pur_front.sv
// Front end: accepts serial numbers, flags out-of-range ranks and peels off
// factorial digits, most significant first, one per cycle unless the queue is full. Depends on pur_pkg.
module pur_front
  import pur_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cnt_t               n_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [SerialW-1:0] serial_i,
  output logic               push_o,
  output pur_entry_t         entry_o,
  input  logic               full_i
);

  typedef enum logic [1:0] {
    FrIdle = 2'b01,
    FrBusy = 2'b10
  } fr_state_e;

  fr_state_e          state_q, state_d;
  logic [SerialW-1:0] rem_q, rem_d;
  cnt_t               k_q, k_d;
  logic               oor_q, oor_d;

  logic [SerialW:0]   diff [MaxItems];
  cnt_t               dig;
  logic [SerialW-1:0] rem_nxt;
  logic               accept;
  logic               done;

  // Largest d with d * k! <= remainder; all compares run in parallel.
  always_comb begin
    dig     = '0;
    rem_nxt = rem_q;
    for (int d = 0; d < MaxItems; d++) begin
      diff[d] = {1'b0, rem_q} - {1'b0, MulTab[k_q][d]};
      if (!diff[d][SerialW]) begin
        dig     = cnt_t'(d);
        rem_nxt = diff[d][SerialW-1:0];
      end
    end
  end

  assign push_o        = (state_q == FrBusy) && !full_i;
  assign done          = push_o && (k_q == '0);
  assign in_ready_o    = (state_q == FrIdle) || done;
  assign accept        = in_valid_i && in_ready_o;
  assign entry_o.digit = oor_q ? '0 : dig;
  assign entry_o.last  = (k_q == '0);
  assign entry_o.oor   = oor_q;

  always_comb begin
    state_d = state_q;
    rem_d   = rem_q;
    k_d     = k_q;
    oor_d   = oor_q;
    if (push_o) begin
      rem_d = rem_nxt;
      k_d   = k_q - cnt_t'(1);
      if (done) begin
        state_d = FrIdle;
      end
    end
    if (accept) begin
      state_d = FrBusy;
      rem_d   = serial_i;
      oor_d   = (serial_i >= fact_lut(n_i));
      k_d     = oor_d ? '0 : n_i - cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FrIdle;
      k_q     <= '0;
      oor_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      oor_q   <= oor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
  end

endmodule

>>> hdl/pur_queue.sv
// Small FIFO of digit entries between the front and the back end.
// Depends on pur_pkg.
module pur_queue
  import pur_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  pur_entry_t entry_i,
  output logic       full_o,
  input  logic       pop_i,
  output pur_entry_t entry_o,
  output logic       empty_o
);

  pur_entry_t        mem_q [QueueDepth];
  logic [QPtrW-1:0]  wptr_q, rptr_q;
  logic [QPtrW:0]    fill_q;

  assign full_o  = (fill_q == (QPtrW+1)'(QueueDepth));
  assign empty_o = (fill_q == '0);
  assign entry_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        fill_q <= fill_q + (QPtrW+1)'(1);
      end else if (pop_i && !push_i) begin
        fill_q <= fill_q - (QPtrW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= entry_i;
    end
  end

endmodule

>>> hdl/pur_back.sv
// Back end: turns each digit into a pick by walking cyclically past used
// positions, and holds the result in an output register. Depends on pur_pkg.
module pur_back
  import pur_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cnt_t       n_i,
  input  pur_entry_t entry_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cnt_t       slot_o,
  output cnt_t       element_o,
  output logic       last_o,
  output logic       oor_o
);

  logic [MaxItems-1:0] used_q;
  cnt_t                start_q;
  cnt_t                slot_q;
  logic                valid_q;
  cnt_t                slot_out_q, elem_out_q;
  logic                last_out_q, oor_out_q;

  logic [MaxItems-1:0] unused, upper;
  cnt_t                cnt_upper;
  cnt_t                ord;
  cnt_t                pick;
  cnt_t                pick_inc;

  // Cyclic order from start: positions at or above start first, then wrap.
  always_comb begin
    for (int j = 0; j < MaxItems; j++) begin
      unused[j] = !used_q[j] && (cnt_t'(j) < n_i);
      upper[j]  = (cnt_t'(j) >= start_q);
    end
    cnt_upper = popcount(unused & upper);
    pick      = '0;
    ord       = '0;
    for (int j = 0; j < MaxItems; j++) begin
      if (upper[j]) begin
        ord = popcount(unused & upper & MaxItems'((1 << j) - 1));
      end else begin
        ord = cnt_upper + popcount(unused & ~upper & MaxItems'((1 << j) - 1));
      end
      if (unused[j] && (ord == entry_i.digit)) begin
        pick = cnt_t'(j);
      end
    end
    pick_inc = (pick + cnt_t'(1) == n_i) ? '0 : pick + cnt_t'(1);
  end

  assign pop_o = !empty_i && (!valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q  <= '0;
      start_q <= '0;
      slot_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        if (entry_i.last || entry_i.oor) begin
          used_q  <= '0;
          start_q <= '0;
          slot_q  <= '0;
        end else begin
          used_q[pick] <= 1'b1;
          start_q      <= pick_inc;
          slot_q       <= slot_q + cnt_t'(1);
        end
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      slot_out_q <= entry_i.oor ? '0 : slot_q;
      elem_out_q <= entry_i.oor ? '0 : pick;
      last_out_q <= entry_i.last || entry_i.oor;
      oor_out_q  <= entry_i.oor;
    end
  end

  assign out_valid_o = valid_q;
  assign slot_o      = slot_out_q;
  assign element_o   = elem_out_q;
  assign last_o      = last_out_q;
  assign oor_o       = oor_out_q;

endmodule

>>> hdl/permutation_unrank_rotating_core.sv
// Permutation unranking core: each serial number accepted on in_if yields
// item_count transactions on out_if (slot, original element index, last),
// or a single flagged transaction when the serial is item_count! or more.
// The front end pushes each factorial digit into the queue while it is not
// full and accepts the next serial in the cycle that pushes the last digit;
// the back end emits one result per cycle while the queue holds a digit and
// the output is not stalled. A zero item_count acts as one, above twelve as twelve.
// A four-entry digit queue lets front and back stall independently.
// Depends on pur_pkg, pur_if, pur_front, pur_queue and pur_back.
module permutation_unrank_rotating_core
  import pur_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  cnt_t      cfg_wdata_i,
  pur_in_if.sink    in_if,
  pur_out_if.source out_if
);

  cnt_t       item_count_q;
  cnt_t       n_eff;
  logic       push, full, pop, empty;
  pur_entry_t q_in, q_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_count_q <= cnt_t'(1);
    end else if (cfg_we_i) begin
      item_count_q <= cfg_wdata_i;
    end
  end

  assign n_eff = eff_count(item_count_q);

  pur_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .n_i        (n_eff),
    .in_valid_i (in_if.valid),
    .in_ready_o (in_if.ready),
    .serial_i   (in_if.serial_number),
    .push_o     (push),
    .entry_o    (q_in),
    .full_i     (full)
  );

  pur_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (q_in),
    .full_o  (full),
    .pop_i   (pop),
    .entry_o (q_out),
    .empty_o (empty)
  );

  pur_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .n_i         (n_eff),
    .entry_i     (q_out),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .slot_o      (out_if.slot),
    .element_o   (out_if.element_index),
    .last_o      (out_if.last),
    .oor_o       (out_if.out_of_range)
  );

endmodule

>>> hdl/pur_checker.sv
// Port-level checker for the permutation unranking core, with its bind.
// Depends on pur_pkg.
module pur_checker
  import pur_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic out_valid_i,
  input logic out_ready_i,
  input cnt_t slot_i,
  input cnt_t element_i,
  input logic last_i,
  input logic oor_i
);

  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped while stalled");

  a_oor_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && oor_i |-> last_i && (slot_i == '0) && (element_i == '0))
    else $error("out-of-range transaction malformed");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (slot_i < cnt_t'(MaxItems)) && (element_i < cnt_t'(MaxItems)))
    else $error("slot or element index out of range");

  a_slot_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_i ##1 out_valid_i |->
      slot_i == $past(slot_i) + cnt_t'(1) || !$past(out_valid_i && out_ready_i))
    else $error("slot sequence broken");

endmodule

bind permutation_unrank_rotating_core pur_checker u_pur_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_if.valid),
  .out_ready_i (out_if.ready),
  .slot_i      (out_if.slot),
  .element_i   (out_if.element_index),
  .last_i      (out_if.last),
  .oor_i       (out_if.out_of_range)
);

>>> tb/sv/tb_permutation_unrank_rotating_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for permutation_unrank_rotating_core: ranks in, one
// transaction per slot out, checked against an in-bench unranking predictor.
// Depends on pur_pkg, pur_if and the core.
module tb_permutation_unrank_rotating_core;
  import pur_pkg::*;

  localparam int SettleCycles = 4;
  localparam int TailCycles   = 20;
  localparam int StallLimit   = 2000;
  localparam int MaxReported  = 10;
  localparam int PhaseItems   = 40;
  localparam int PhaseCount   = 12;

  typedef logic [SerialW-1:0] serial_t;

  typedef struct packed {
    cnt_t slot;
    cnt_t element_index;
    logic last;
    logic out_of_range;
  } perm_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  cnt_t cfg_wdata_i;

  pur_in_if  serial_ch ();
  pur_out_if perm_ch ();

  permutation_unrank_rotating_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (serial_ch),
    .out_if      (perm_ch)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench copy of the item_count register, reset value 1.
  cnt_t         item_count_q = cnt_t'(1);
  perm_result_t perm_q[$];
  int           error_count = 0;
  int           stall_cycles = 0;
  bit           calm = 1'b0;

  function automatic int unsigned fact_of(input int unsigned k);
    case (k)
      0, 1:    return 1;
      2:       return 2;
      3:       return 6;
      4:       return 24;
      5:       return 120;
      6:       return 720;
      7:       return 5040;
      8:       return 40320;
      9:       return 362880;
      10:      return 3628800;
      11:      return 39916800;
      default: return 479001600;
    endcase
  endfunction

  function automatic int unsigned active_items();
    if (item_count_q == '0) return 1;
    if (item_count_q > cnt_t'(MaxItems)) return MaxItems;
    return int'(item_count_q);
  endfunction

  // Expected permutation for one rank, pushed slot by slot.
  function automatic void unrank_serial(input serial_t serial);
    int unsigned         n;
    int unsigned         rank;
    int unsigned         start;
    int unsigned         cnt;
    int unsigned         pick;
    int unsigned         j;
    bit                  found;
    logic [MaxItems-1:0] taken;
    perm_result_t        res;
    n    = active_items();
    rank = 32'(serial);
    if (rank >= fact_of(n)) begin
      res = '{slot: '0, element_index: '0, last: 1'b1, out_of_range: 1'b1};
      perm_q.push_back(res);
      return;
    end
    taken = '0;
    start = 0;
    for (int unsigned i = 0; i < n; i++) begin
      cnt   = (rank % fact_of(n - i)) / fact_of(n - i - 1);
      pick  = 0;
      found = 1'b0;
      // Walk cyclically from just past the previous pick, skipping used slots.
      for (int unsigned k = 0; k < n; k++) begin
        j = (start + k) % n;
        if (!found && !taken[j[3:0]]) begin
          if (cnt == 0) begin
            pick  = j;
            found = 1'b1;
          end else begin
            cnt--;
          end
        end
      end
      taken[pick[3:0]] = 1'b1;
      start = (pick + 1) % n;
      res = '{slot: cnt_t'(i), element_index: cnt_t'(pick),
              last: (i + 1 == n), out_of_range: 1'b0};
      perm_q.push_back(res);
    end
  endfunction

  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 5);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_serial(input serial_t serial);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      serial_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    serial_ch.valid         <= 1'b1;
    serial_ch.serial_number <= serial;
    do @(posedge clk_i); while (!serial_ch.ready);
    unrank_serial(serial);
    @(negedge clk_i);
  endtask

  // Wait for every outstanding transaction, then let the pipeline settle.
  task automatic drain();
    serial_ch.valid <= 1'b0;
    while (perm_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_item_count(input cnt_t value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i     <= 1'b0;
    item_count_q = value;
  endtask

  // Count of one after reset, no register write.
  task automatic test_reset_count();
    send_serial(serial_t'(0));
    send_serial(serial_t'(1));
    send_serial('1);
  endtask

  // A zero count behaves as one item.
  task automatic test_zero_count();
    write_item_count(cnt_t'(0));
    send_serial(serial_t'(0));
    send_serial(serial_t'(1));
  endtask

  task automatic test_small_count();
    write_item_count(cnt_t'(3));
    for (int r = 0; r <= 6; r++) send_serial(serial_t'(r));
  endtask

  task automatic test_full_count();
    write_item_count(cnt_t'(MaxItems));
    send_serial(serial_t'(0));
    send_serial(serial_t'(479001599));
    send_serial(serial_t'(479001600));
    send_serial('1);
  endtask

  // Counts above the maximum saturate.
  task automatic test_saturated_count();
    write_item_count(cnt_t'(15));
    send_serial(serial_t'(479001599));
    send_serial(serial_t'(479001600));
    write_item_count(cnt_t'(13));
    send_serial(serial_t'(1));
  endtask

  task automatic test_random_ranks();
    cnt_t        count;
    int unsigned lim;
    int unsigned pick;
    serial_t     serial;
    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0:       count = cnt_t'(1);
        1:       count = cnt_t'(MaxItems);
        2:       count = cnt_t'(0);
        3:       count = cnt_t'(15);
        default: count = cnt_t'($urandom_range(0, 15));
      endcase
      write_item_count(count);
      calm = ($urandom_range(0, 3) == 0);
      lim  = fact_of(active_items());
      for (int k = 0; k < PhaseItems; k++) begin
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          serial = serial_t'($urandom_range(0, lim - 1));
        end else if (pick == 7) begin
          serial = serial_t'(lim - $urandom_range(0, 1));
        end else if (pick == 8) begin
          serial = serial_t'($urandom);
        end else begin
          serial = '0;
        end
        send_serial(serial);
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni                  = 1'b0;
    cfg_we_i                = 1'b0;
    cfg_wdata_i             = '0;
    serial_ch.valid         = 1'b0;
    serial_ch.serial_number = '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_count();
    test_zero_count();
    test_small_count();
    test_full_count();
    test_saturated_count();
    test_random_ranks();
    drain();
    repeat (TailCycles) @(negedge clk_i);
    if (error_count == 0 && perm_q.size() == 0) begin
      $display("PASS permutation_unrank_rotating_core");
    end else begin
      $display("FAIL permutation_unrank_rotating_core");
    end
    $finish;
  end

  // Result side back-pressure, redrawn after every transaction.
  initial begin
    int unsigned gap;
    perm_ch.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        perm_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      perm_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(perm_ch.valid && perm_ch.ready));
      @(negedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    perm_result_t want;
    perm_result_t got;
    if (rst_ni && perm_ch.valid && perm_ch.ready) begin
      got = '{slot: perm_ch.slot, element_index: perm_ch.element_index,
              last: perm_ch.last, out_of_range: perm_ch.out_of_range};
      if (perm_q.size() == 0) begin
        if (error_count < MaxReported) begin
          $display("%0t unexpected transaction slot %0d elem %0d last %0b oor %0b",
                   $realtime, got.slot, got.element_index, got.last, got.out_of_range);
        end
        error_count++;
      end else begin
        want = perm_q.pop_front();
        if (got !== want) begin
          if (error_count < MaxReported) begin
            $display("%0t mismatch slot %0d/%0d elem %0d/%0d last %0b/%0b oor %0b/%0b",
                     $realtime, want.slot, got.slot, want.element_index,
                     got.element_index, want.last, got.last,
                     want.out_of_range, got.out_of_range);
          end
          error_count++;
        end
      end
    end
  end

  // Ends a run in which no transaction moves for too long.
  always @(posedge clk_i) begin
    if ((serial_ch.valid && serial_ch.ready) || (perm_ch.valid && perm_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("FAIL permutation_unrank_rotating_core");
      $finish;
    end
  end

endmodule

>>> filelist.f
hdl/pur_pkg.sv
hdl/pur_if.sv
hdl/pur_front.sv
hdl/pur_queue.sv
hdl/pur_back.sv
hdl/permutation_unrank_rotating_core.sv
hdl/pur_checker.sv
tb/sv/tb_permutation_unrank_rotating_core.sv
